// File: hw/rtl/status_led_blink_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Status LED blink sequencer assertion macros
// Short forms for the concurrent checks used inside the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_BLINK_SEQUENCER_ASSERT_SVH
`define STATUS_LED_BLINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("status LED sequencer check failed");

// Next-cycle implication, disabled during reset.
`define SLBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("status LED sequencer check failed");

`endif

// File: hw/rtl/slbs_pkg.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer package
// Shared widths, blink timing constants, register indexes and bundle types.
// ----------------------------------------------------------------------------
package slbs_pkg;

  // Field widths.
  localparam int ELAPSED_W   = 20;
  localparam int LEVEL_W     = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int TIMER_W_DEF = 21;

  // Blink step durations in microseconds.
  localparam int unsigned T_SHORT  = 100000;
  localparam int unsigned T_FAULT  = 700000;
  localparam int unsigned T_STREAM = 500000;
  localparam int unsigned T_LONG   = 900000;

  // Charge level code for a full battery.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEDS_ALWAYS_ON  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_ONLY_MODE = 1'b1;

  // Stream pattern runs through phases zero to five.
  localparam logic [2:0] STREAM_LAST = 3'd5;

  // Device status flags that steer the pattern choice.
  typedef struct packed {
    logic usb_on;
    logic sys_error;
    logic sd_mounted;
    logic sd_card_off;
    logic camera_failed;
    logic record_requested;
    logic record_started;
    logic stream_started;
  } status_t;

  // Configuration bits.
  typedef struct packed {
    logic leds_always_on;
    logic sound_only_mode;
  } cfg_t;

  // LED level and per-pattern phase counters.
  typedef struct packed {
    logic       led_level;
    logic [1:0] fault_phase;
    logic [1:0] audio_phase;
    logic [2:0] stream_phase;
  } pattern_state_t;

endpackage

// File: hw/rtl/slbs_if.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer channels
// Valid/ready interfaces for the poll tick, the LED result and config writes.
// ----------------------------------------------------------------------------

// Poll tick channel: elapsed time and status flags.
interface slbs_tick_if
  import slbs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_us;
  logic                 usb_on;
  logic                 sys_error;
  logic                 sd_mounted;
  logic                 sd_card_off;
  logic                 camera_failed;
  logic                 record_requested;
  logic                 record_started;
  logic                 stream_started;
  logic                 charger_in;
  logic [LEVEL_W-1:0]   charge_level;
  logic                 battery_flag;

  modport source (
    output valid, elapsed_us, usb_on, sys_error, sd_mounted, sd_card_off,
           camera_failed, record_requested, record_started, stream_started,
           charger_in, charge_level, battery_flag,
    input  ready
  );
  modport sink (
    input  valid, elapsed_us, usb_on, sys_error, sd_mounted, sd_card_off,
           camera_failed, record_requested, record_started, stream_started,
           charger_in, charge_level, battery_flag,
    output ready
  );
endinterface

// LED result channel.
interface slbs_led_if;
  logic valid;
  logic ready;
  logic status_led;
  logic charge_led;
  logic battery_led;

  modport source (output valid, status_led, charge_led, battery_led, input ready);
  modport sink   (input valid, status_led, charge_led, battery_led, output ready);
endinterface

// Configuration write channel.
interface slbs_cfg_if
  import slbs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/slbs_pattern.sv
// ----------------------------------------------------------------------------
// Status LED pattern step
// Adds elapsed time to the saturating timer, picks the pattern by priority
// and fires the current step when its duration has been reached.
// ----------------------------------------------------------------------------
module slbs_pattern
  import slbs_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_W_DEF
) (
  input  logic [TIMER_WIDTH-1:0] timer,
  input  logic [ELAPSED_W-1:0]   elapsed_us,
  input  status_t                status,
  input  cfg_t                   cfg,
  input  pattern_state_t         state,
  output logic [TIMER_WIDTH-1:0] timer_next,
  output pattern_state_t         state_next
);

  localparam logic [TIMER_WIDTH-1:0] THR_SHORT  = TIMER_WIDTH'(T_SHORT);
  localparam logic [TIMER_WIDTH-1:0] THR_FAULT  = TIMER_WIDTH'(T_FAULT);
  localparam logic [TIMER_WIDTH-1:0] THR_STREAM = TIMER_WIDTH'(T_STREAM);
  localparam logic [TIMER_WIDTH-1:0] THR_LONG   = TIMER_WIDTH'(T_LONG);

  logic [TIMER_WIDTH:0]   sum;
  logic [TIMER_WIDTH-1:0] sat;
  logic [TIMER_WIDTH-1:0] thr;
  logic                   lvl;
  logic                   active;
  logic                   fire;
  logic                   adv_fault;
  logic                   adv_audio;
  logic                   adv_stream;
  logic                   storage_fault;

  // Saturating timer add.
  assign sum = {1'b0, timer} + (TIMER_WIDTH + 1)'(elapsed_us);
  assign sat = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];

  assign storage_fault = !status.sd_mounted || status.sd_card_off ||
                         (status.camera_failed && status.record_requested);

  // Pattern choice: step duration, target level and which phase advances.
  always_comb begin
    thr        = THR_SHORT;
    lvl        = 1'b0;
    active     = 1'b0;
    adv_fault  = 1'b0;
    adv_audio  = 1'b0;
    adv_stream = 1'b0;
    priority if (!cfg.leds_always_on && !status.usb_on) begin
      active = 1'b0;
    end else if (status.sys_error) begin
      active = 1'b1;
      lvl    = !state.led_level;
    end else if (storage_fault) begin
      active    = 1'b1;
      adv_fault = 1'b1;
      lvl       = state.fault_phase[0];
      thr       = (state.fault_phase == 2'd1) ? THR_FAULT : THR_SHORT;
    end else if (status.record_started && !cfg.sound_only_mode) begin
      active = 1'b1;
      lvl    = !state.led_level;
      thr    = state.led_level ? THR_LONG : THR_SHORT;
    end else if (status.record_started) begin
      active    = 1'b1;
      adv_audio = 1'b1;
      lvl       = state.audio_phase[0];
      thr       = (state.audio_phase == 2'd1 || state.audio_phase == 2'd2) ?
                  THR_LONG : THR_SHORT;
    end else if (status.stream_started) begin
      active     = (state.stream_phase <= STREAM_LAST);
      adv_stream = 1'b1;
      lvl        = state.stream_phase[0];
      thr        = (state.stream_phase == 3'd1) ? THR_STREAM : THR_SHORT;
    end else begin
      active = 1'b1;
      lvl    = !state.led_level;
      thr    = state.led_level ? THR_SHORT : THR_LONG;
    end
  end

  assign fire = active && (sat >= thr);

  // Apply the step: a fired step sets the LED, restarts the timer and moves
  // its own phase on. The off pattern forces the LED dark without a restart.
  always_comb begin
    state_next = state;
    timer_next = sat;
    if (!cfg.leds_always_on && !status.usb_on) begin
      state_next.led_level = 1'b0;
    end
    if (fire) begin
      state_next.led_level = lvl;
      timer_next           = '0;
      if (adv_fault) begin
        state_next.fault_phase = state.fault_phase + 2'd1;
      end
      if (adv_audio) begin
        state_next.audio_phase = state.audio_phase + 2'd1;
      end
      if (adv_stream) begin
        state_next.stream_phase = (state.stream_phase == STREAM_LAST) ?
                                  3'd0 : state.stream_phase + 3'd1;
      end
    end
  end

endmodule

// File: hw/rtl/status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer
// Drives the status, charging and battery LEDs from periodic poll ticks.
// ----------------------------------------------------------------------------
// Each tick beat returns one LED beat. A tick passes through an input
// register and an output register, and a new tick is taken every cycle
// as long as the LED side keeps up. The per-tick loop is one saturating
// timer add, one threshold compare and a phase increment, all done in the
// cycle a tick moves from the input register to the output register.
// Configuration writes are taken at any time and should be made while no
// ticks are in flight.
`include "status_led_blink_sequencer_assert.svh"

module status_led_blink_sequencer
  import slbs_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_W_DEF
) (
  input  logic       clk,
  input  logic       rst,
  slbs_cfg_if.sink   cfg,
  slbs_tick_if.sink  tick,
  slbs_led_if.source leds
);

  // Configuration registers.
  cfg_t cfg_reg;

  // Input register.
  logic                 s1_valid;
  logic [ELAPSED_W-1:0] s1_elapsed_us;
  status_t              s1_status;
  logic                 s1_charger_in;
  logic [LEVEL_W-1:0]   s1_charge_level;
  logic                 s1_battery_flag;

  // Sequencer state.
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  pattern_state_t         state;
  pattern_state_t         state_next;

  logic out_free;
  logic s1_adv;
  logic charging;

  // Handshake: the output register frees when empty or being taken.
  assign out_free   = !leds.valid || leds.ready;
  assign s1_adv     = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;
  assign cfg.ready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LEDS_ALWAYS_ON:  cfg_reg.leds_always_on  <= cfg.data;
        REG_SOUND_ONLY_MODE: cfg_reg.sound_only_mode <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_elapsed_us   <= tick.elapsed_us;
      s1_status       <= '{usb_on:           tick.usb_on,
                           sys_error:        tick.sys_error,
                           sd_mounted:       tick.sd_mounted,
                           sd_card_off:      tick.sd_card_off,
                           camera_failed:    tick.camera_failed,
                           record_requested: tick.record_requested,
                           record_started:   tick.record_started,
                           stream_started:   tick.stream_started};
      s1_charger_in   <= tick.charger_in;
      s1_charge_level <= tick.charge_level;
      s1_battery_flag <= tick.battery_flag;
    end
  end

  // Pattern step for the tick in the input register.
  slbs_pattern #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_pattern (
    .timer      (timer),
    .elapsed_us (s1_elapsed_us),
    .status     (s1_status),
    .cfg        (cfg_reg),
    .state      (state),
    .timer_next (timer_next),
    .state_next (state_next)
  );

  // State update as the tick moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
      state <= '0;
    end else if (s1_adv) begin
      timer <= timer_next;
      state <= state_next;
    end
  end

  assign charging = s1_charger_in && (s1_charge_level != LEVEL_FULL);

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      leds.valid <= 1'b0;
    end else if (out_free) begin
      leds.valid <= s1_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      leds.status_led  <= state_next.led_level;
      leds.charge_led  <= charging;
      leds.battery_led <= charging ? 1'b0 : s1_battery_flag;
    end
  end

  // Checks.
  `SLBS_ASSERT_NOW(a_stream_phase_range, clk, rst, 1'b1, state.stream_phase <= STREAM_LAST)
  `SLBS_ASSERT_NOW(a_no_overrun, clk, rst, leds.valid && !leds.ready, !s1_adv)
  `SLBS_ASSERT_NEXT(a_led_tracks_state, clk, rst, s1_adv, leds.status_led == state.led_level)
  `SLBS_ASSERT_NEXT(a_state_holds, clk, rst, !s1_adv, $stable(timer) && $stable(state))
  `SLBS_ASSERT_NOW(a_leds_exclusive, clk, rst, leds.valid, !(leds.charge_led && leds.battery_led))

endmodule
